/* src/ttpc_pkg.sv */
// ----------------------------------------------------------------------------
// ttpc_pkg
// Shared types and constants for the tap tempo phase clock: opcodes,
// register indexes, reset values and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ttpc_pkg;

    // Divider width: holds clock_speed * 600 and 2^PHASE_BITS
    localparam int DIV_W     = 34;
    localparam int DIV_CNT_W = 6;

    // Opcodes
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_TAP     = 3'd1;
    localparam logic [2:0] OP_SYNC    = 3'd2;
    localparam logic [2:0] OP_SET_BPM = 3'd3;
    localparam logic [2:0] OP_SET_DIV = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_CLOCK_SPEED = 3'd0;
    localparam logic [2:0] CFG_SUB_SHIFT   = 3'd1;
    localparam logic [2:0] CFG_MIN_INTV    = 3'd2;
    localparam logic [2:0] CFG_MAX_INTV    = 3'd3;
    localparam logic [2:0] CFG_WRAP_THR    = 3'd4;
    localparam logic [2:0] CFG_EXT_SYNC    = 3'd5;

    // Configuration reset values
    localparam logic [23:0] RST_CLOCK_SPEED = 24'd48000;
    localparam logic [4:0]  RST_SUB_SHIFT   = 5'd2;
    localparam logic [31:0] RST_MIN_INTV    = 32'd4800;
    localparam logic [31:0] RST_MAX_INTV    = 32'd480000;
    localparam logic [31:0] RST_WRAP_THR    = 32'hF000_0000;

    // Tempo scale: beats per minute times ten, per beat per second
    localparam logic [9:0] TEMPO_SCALE = 10'd600;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;      // input request taken this cycle
        logic cfg_we;      // configuration write this cycle
        logic start_div2;  // second division of a tempo set
        logic load_step;   // load the phase step from the quotient
        logic load_out;    // capture a result into the output register
    } ttpc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_div;    // current input request needs a division
        logic div_done;    // divider finished
        logic bpm_stage1;  // division in flight is ticks-per-beat
        logic quo_zero;    // quotient is zero
    } ttpc_status_t;

endpackage

/* src/tap_tempo_phase_clock.sv */
// ----------------------------------------------------------------------------
// tap_tempo_phase_clock
// Tick, sync reset and set divisor requests: result registered on acceptance
//   if the output is free, one request per cycle sustained without out_stall.
// Tap with a new tempo: one 34-step division, set bpm10: two 34-step
//   divisions, in the shared bit-serial divider, then readout READ1, READ2.
// A configuration write holds off input requests through CFG1 and CFG2.
// Reset (rst_n, asynchronous) restores register defaults and clears state.
// ----------------------------------------------------------------------------
module tap_tempo_phase_clock #(
    parameter int PHASE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input requests
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            opcode,
    input  logic [31:0]           value,
    // results
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PHASE_BITS-1:0] phase,
    output logic                  beat_pulse,
    output logic                  subclock_pulse,
    output logic [31:0]           tick_count,
    output logic [15:0]           tempo_bpm10,
    output logic                  tap_accepted,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

    ttpc_pkg::ttpc_cmd_t    cmd;
    ttpc_pkg::ttpc_status_t status;

    ttpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    ttpc_datapath #(
        .PHASE_BITS (PHASE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .opcode         (opcode),
        .value          (value),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .phase          (phase),
        .beat_pulse     (beat_pulse),
        .subclock_pulse (subclock_pulse),
        .tick_count     (tick_count),
        .tempo_bpm10    (tempo_bpm10),
        .tap_accepted   (tap_accepted)
    );

endmodule

/* src/ttpc_div.sv */
// ----------------------------------------------------------------------------
// ttpc_div
// Restoring unsigned divider, one quotient bit per cycle. done pulses for
// one cycle when the quotient is ready, which holds until the next start.
// ----------------------------------------------------------------------------
module ttpc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ttpc_pkg::DIV_W-1:0]   dividend,
    input  logic [ttpc_pkg::DIV_W-1:0]   divisor,
    output logic                         done,
    output logic [ttpc_pkg::DIV_W-1:0]   quotient
);

    localparam int DW = ttpc_pkg::DIV_W;
    localparam int CW = ttpc_pkg::DIV_CNT_W;

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;

    logic [DW:0]   rem_shift;
    logic [DW:0]   diff;
    logic          q_bit;

    // One restoring step
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DW-1]};
        diff      = rem_shift - {1'b0, den_reg};
        q_bit     = ~diff[DW];
    end

    // Step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CW'(1));
            if (start)
            begin
                cnt_reg <= CW'(DW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= q_bit ? diff[DW-1:0] : rem_shift[DW-1:0];
            quo_reg <= {quo_reg[DW-2:0], q_bit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* src/ttpc_datapath.sv */
// ----------------------------------------------------------------------------
// ttpc_datapath
// Phase accumulator, subclock counter, tap interval logic, configuration
// registers, tempo readout pipeline, divider and output register.
// ----------------------------------------------------------------------------
module ttpc_datapath #(
    parameter int PHASE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ttpc_pkg::ttpc_cmd_t    cmd,
    output ttpc_pkg::ttpc_status_t status,
    input  logic [2:0]             opcode,
    input  logic [31:0]            value,
    input  logic [2:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    output logic [PHASE_BITS-1:0]  phase,
    output logic                   beat_pulse,
    output logic                   subclock_pulse,
    output logic [31:0]            tick_count,
    output logic [15:0]            tempo_bpm10,
    output logic                   tap_accepted
);

    localparam int DW = ttpc_pkg::DIV_W;
    localparam int TW = PHASE_BITS + 24;     // step * clock_speed
    localparam int SW = TW + 10;             // times the tempo scale
    localparam logic [DW-1:0] PHASE_ONE = DW'(1) << PHASE_BITS;

    // Configuration registers
    logic [23:0] cs_reg;
    logic [4:0]  shift_reg;
    logic [31:0] min_reg;
    logic [31:0] max_reg;
    logic [31:0] wrap_reg;
    logic        ext_reg;

    // Clock state
    logic [PHASE_BITS-1:0] phase_reg,     phase_next;
    logic [PHASE_BITS-1:0] step_reg,      step_next;
    logic                  beat_reg,      beat_next;
    logic                  sub_reg,       sub_next;
    logic [15:0]           sub_count_reg, sub_count_next;
    logic [15:0]           sub_div_reg,   sub_div_next;
    logic                  pending_reg,   pending_next;
    logic [31:0]           ticks_reg,     ticks_next;
    logic [31:0]           last_tap_reg,  last_tap_next;
    logic                  armed_reg,     armed_next;
    logic                  tap_acc_reg,   tap_acc_next;
    logic                  op_tap_reg,    op_tap_next;
    logic                  bpm_s1_reg,    bpm_s1_next;

    // Tempo readout pipeline
    logic [TW-1:0] t_reg;
    logic [15:0]   tempo_reg;
    logic [SW-1:0] t_scaled;
    logic [33:0]   tempo_full;

    // Output register
    logic [PHASE_BITS-1:0] phase_out_reg;
    logic                  beat_out_reg;
    logic                  sub_out_reg;
    logic [31:0]           ticks_out_reg;
    logic [15:0]           tempo_out_reg;
    logic                  tap_out_reg;

    // Working signals
    logic                  sync_ok;
    logic [31:0]           interval;
    logic                  in_range;
    logic [PHASE_BITS-1:0] phase_sum;
    logic                  wrap_beat;
    logic [PHASE_BITS-1:0] prev_shift;
    logic [PHASE_BITS-1:0] cur_shift;
    logic [15:0]           cnt_inc;
    logic                  sub_hit;
    logic                  pend_tick;
    logic                  need_div;

    // Divider
    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic [DW-1:0] div_divisor;
    logic          div_done;
    logic [DW-1:0] quotient;
    logic [DW-1:0] cs_scaled;
    logic [PHASE_BITS-1:0] step_sat;

    ttpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // Shared terms for the item logic
    always_comb
    begin
        sync_ok    = ~(ext_reg && (32'(phase_reg) > wrap_reg));
        interval   = value - last_tap_reg;
        in_range   = ~((interval < min_reg) || (interval > max_reg));
        phase_sum  = phase_reg + step_reg;
        wrap_beat  = phase_reg > phase_sum;
        prev_shift = phase_reg << shift_reg;
        cur_shift  = phase_sum << shift_reg;
        cnt_inc    = (prev_shift > cur_shift) ? (sub_count_reg + 16'd1) : sub_count_reg;
        sub_hit    = cnt_inc >= sub_div_reg;
        pend_tick  = pending_reg | sub_hit;
        need_div   = ((opcode == ttpc_pkg::OP_TAP) && armed_reg && in_range
                      && (interval != '0))
                   || ((opcode == ttpc_pkg::OP_SET_BPM) && (value != '0));
        step_sat   = (|quotient[DW-1:PHASE_BITS]) ? '1 : quotient[PHASE_BITS-1:0];
    end

    // Next state per item
    always_comb
    begin
        phase_next     = phase_reg;
        step_next      = step_reg;
        beat_next      = beat_reg;
        sub_next       = sub_reg;
        sub_count_next = sub_count_reg;
        sub_div_next   = sub_div_reg;
        pending_next   = pending_reg;
        ticks_next     = ticks_reg;
        last_tap_next  = last_tap_reg;
        armed_next     = armed_reg;
        tap_acc_next   = tap_acc_reg;
        op_tap_next    = op_tap_reg;
        bpm_s1_next    = bpm_s1_reg;

        if (cmd.accept)
        begin
            tap_acc_next = 1'b0;
            op_tap_next  = (opcode == ttpc_pkg::OP_TAP);
            bpm_s1_next  = (opcode == ttpc_pkg::OP_SET_BPM);
            case (opcode)
                ttpc_pkg::OP_TICK:
                begin
                    phase_next     = phase_sum;
                    beat_next      = wrap_beat;
                    sub_next       = sub_hit;
                    ticks_next     = ticks_reg + 32'd1;
                    sub_count_next = sub_hit ? 16'd0 : cnt_inc;
                    pending_next   = pend_tick;
                    // resync the subclock on the main beat
                    if (pend_tick && wrap_beat)
                    begin
                        sub_count_next = 16'd0;
                        pending_next   = 1'b0;
                    end
                end
                ttpc_pkg::OP_TAP:
                begin
                    if (!armed_reg)
                    begin
                        last_tap_next = value;
                        armed_next    = 1'b1;
                    end
                    else if (!in_range)
                    begin
                        armed_next = 1'b0;
                    end
                    else
                    begin
                        last_tap_next = value;
                        if (sync_ok)
                        begin
                            phase_next   = '0;
                            beat_next    = 1'b1;
                            pending_next = 1'b0;
                        end
                    end
                end
                ttpc_pkg::OP_SYNC:
                begin
                    if (sync_ok)
                    begin
                        phase_next   = '0;
                        beat_next    = 1'b1;
                        pending_next = 1'b0;
                    end
                end
                ttpc_pkg::OP_SET_DIV:
                begin
                    sub_div_next = (|value[31:16]) ? 16'hFFFF : value[15:0];
                    pending_next = 1'b1;
                    if (ext_reg && sync_ok)
                    begin
                        phase_next   = '0;
                        beat_next    = 1'b1;
                        pending_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.start_div2)
        begin
            bpm_s1_next = 1'b0;
        end

        if (cmd.load_step)
        begin
            step_next    = step_sat;
            tap_acc_next = op_tap_reg;
        end
    end

    // Divider operand select
    always_comb
    begin
        cs_scaled    = DW'(cs_reg) * DW'(ttpc_pkg::TEMPO_SCALE);
        div_start    = (cmd.accept && need_div) || cmd.start_div2;
        div_dividend = (cmd.accept && (opcode == ttpc_pkg::OP_SET_BPM)) ? cs_scaled : PHASE_ONE;
        if (cmd.start_div2)
        begin
            div_divisor = quotient;
        end
        else if (opcode == ttpc_pkg::OP_SET_BPM)
        begin
            div_divisor = DW'(value);
        end
        else
        begin
            div_divisor = DW'(interval);
        end
    end

    // Tempo readout: (step * clock_speed * 600) >> PHASE_BITS, saturated
    always_comb
    begin
        t_scaled   = SW'(t_reg) * SW'(ttpc_pkg::TEMPO_SCALE);
        tempo_full = t_scaled[SW-1:PHASE_BITS];
    end

    // Configuration and clock state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg        <= ttpc_pkg::RST_CLOCK_SPEED;
            shift_reg     <= ttpc_pkg::RST_SUB_SHIFT;
            min_reg       <= ttpc_pkg::RST_MIN_INTV;
            max_reg       <= ttpc_pkg::RST_MAX_INTV;
            wrap_reg      <= ttpc_pkg::RST_WRAP_THR;
            ext_reg       <= 1'b0;
            phase_reg     <= '0;
            step_reg      <= '0;
            beat_reg      <= 1'b0;
            sub_reg       <= 1'b0;
            sub_count_reg <= '0;
            sub_div_reg   <= 16'd1;
            pending_reg   <= 1'b0;
            ticks_reg     <= '0;
            last_tap_reg  <= '0;
            armed_reg     <= 1'b0;
            tap_acc_reg   <= 1'b0;
            op_tap_reg    <= 1'b0;
            bpm_s1_reg    <= 1'b0;
            t_reg         <= '0;
            tempo_reg     <= '0;
        end
        else
        begin
            if (cmd.cfg_we)
            begin
                case (cfg_index)
                    ttpc_pkg::CFG_CLOCK_SPEED: cs_reg    <= cfg_data[23:0];
                    ttpc_pkg::CFG_SUB_SHIFT:   shift_reg <= cfg_data[4:0];
                    ttpc_pkg::CFG_MIN_INTV:    min_reg   <= cfg_data;
                    ttpc_pkg::CFG_MAX_INTV:    max_reg   <= cfg_data;
                    ttpc_pkg::CFG_WRAP_THR:    wrap_reg  <= cfg_data;
                    ttpc_pkg::CFG_EXT_SYNC:    ext_reg   <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            beat_reg      <= beat_next;
            sub_reg       <= sub_next;
            sub_count_reg <= sub_count_next;
            sub_div_reg   <= sub_div_next;
            pending_reg   <= pending_next;
            ticks_reg     <= ticks_next;
            last_tap_reg  <= last_tap_next;
            armed_reg     <= armed_next;
            tap_acc_reg   <= tap_acc_next;
            op_tap_reg    <= op_tap_next;
            bpm_s1_reg    <= bpm_s1_next;
            // free-running readout, registered in t_reg then tempo_reg
            t_reg         <= TW'(step_reg) * TW'(cs_reg);
            tempo_reg     <= (|tempo_full[33:16]) ? 16'hFFFF : tempo_full[15:0];
        end
    end

    // Output register, loaded from the post-item state
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            phase_out_reg <= phase_next;
            beat_out_reg  <= beat_next;
            sub_out_reg   <= sub_next;
            ticks_out_reg <= ticks_next;
            tempo_out_reg <= tempo_reg;
            tap_out_reg   <= tap_acc_next;
        end
    end

    always_comb
    begin
        status.need_div   = need_div;
        status.div_done   = div_done;
        status.bpm_stage1 = bpm_s1_reg;
        status.quo_zero   = (quotient == '0);
    end

    assign phase          = phase_out_reg;
    assign beat_pulse     = beat_out_reg;
    assign subclock_pulse = sub_out_reg;
    assign tick_count     = ticks_out_reg;
    assign tempo_bpm10    = tempo_out_reg;
    assign tap_accepted   = tap_out_reg;

endmodule

/* src/ttpc_ctrl.sv */
// ----------------------------------------------------------------------------
// ttpc_ctrl
// Sequencer for the tap tempo clock: input and configuration handshakes,
// divider sequencing, readout settling and output register control.
// ----------------------------------------------------------------------------
module ttpc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    output logic                   out_valid,
    input  logic                   out_stall,
    output ttpc_pkg::ttpc_cmd_t    cmd,
    input  ttpc_pkg::ttpc_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1,
        ST_DIV2,
        ST_READ1,
        ST_READ2,
        ST_CFG1,
        ST_CFG2,
        ST_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   idle;
    logic   out_free;

    // Handshakes, commands and next state
    always_comb
    begin
        idle       = (state_reg == ST_IDLE);
        out_free   = ~out_valid_reg | ~out_stall;
        in_stall   = ~idle | cfg_valid;
        cfg_ready  = idle;
        cmd        = '0;
        cmd.cfg_we = cfg_valid & idle;
        cmd.accept = in_valid & idle & ~cfg_valid;
        state_next = state_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.cfg_we)
                begin
                    state_next = ST_CFG1;
                end
                else if (cmd.accept)
                begin
                    if (status.need_div)
                    begin
                        state_next = ST_DIV1;
                    end
                    else if (out_free)
                    begin
                        cmd.load_out = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_DIV1:
            begin
                if (status.div_done)
                begin
                    if (status.bpm_stage1)
                    begin
                        // ticks per beat of zero leaves the tempo alone
                        if (status.quo_zero)
                        begin
                            state_next = ST_HOLD;
                        end
                        else
                        begin
                            cmd.start_div2 = 1'b1;
                            state_next     = ST_DIV2;
                        end
                    end
                    else
                    begin
                        cmd.load_step = 1'b1;
                        state_next    = ST_READ1;
                    end
                end
            end
            ST_DIV2:
            begin
                if (status.div_done)
                begin
                    cmd.load_step = 1'b1;
                    state_next    = ST_READ1;
                end
            end
            ST_READ1: state_next = ST_READ2;
            ST_READ2: state_next = ST_HOLD;
            ST_CFG1:  state_next = ST_CFG2;
            ST_CFG2:  state_next = ST_IDLE;
            ST_HOLD:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase

        out_valid_next = cmd.load_out | (out_valid_reg & out_stall);
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the tap tempo phase clock request by request. A request-level
// software copy of the clock state predicts the results the script leaves open; a short
// scripted sequence covers reset values, saturation and the tap corner cases, then
// random request streams run under several register settings while both
// handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // Opcodes the block ignores, and a register index past the list
    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 165;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        bit [31:0] ph;
        bit        beat;
        bit        sub;
        bit [31:0] ticks;
        bit [15:0] tempo;
        bit        tap_ok;
    } clock_result_t;

    typedef struct packed {
        bit            known;
        clock_result_t want;
    } script_expect_t;

    typedef struct packed {
        bit            is_reg;
        bit [2:0]      code;
        bit [31:0]     data;
        bit            known;
        clock_result_t want;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  opcode = ttpc_pkg::OP_TICK;
    logic [31:0] value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] phase;
    logic        beat_pulse;
    logic        subclock_pulse;
    logic [31:0] tick_count;
    logic [15:0] tempo_bpm10;
    logic        tap_accepted;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = ttpc_pkg::CFG_CLOCK_SPEED;
    logic [31:0] cfg_data = '0;

    // Register copies
    bit [23:0] speed_hz;
    bit [4:0]  sub_shift;
    bit [31:0] tap_min;
    bit [31:0] tap_max;
    bit [31:0] sync_guard;
    bit        ext_sync;

    // Clock state copies
    bit [31:0] acc;
    bit [31:0] step;
    bit        beat_q;
    bit        sub_q;
    bit [15:0] sub_cnt;
    bit [15:0] sub_div;
    bit        resync;
    bit [31:0] tick_total;
    bit [31:0] tap_prev;
    bit        tap_held;

    clock_result_t  pending_results[$];
    script_expect_t script_expects[$];
    script_row_t    script[$];

    int        err_count = 0;
    int        result_index = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    int        cycle_count = 0;
    bit [31:0] last_tap_sent = '0;

    tap_tempo_phase_clock dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .phase          (phase),
        .beat_pulse     (beat_pulse),
        .subclock_pulse (subclock_pulse),
        .tick_count     (tick_count),
        .tempo_bpm10    (tempo_bpm10),
        .tap_accepted   (tap_accepted),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #2 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        $display("error: result %0d: %s", result_index, msg);
        err_count++;
    endtask

    // Phase step for a beat length in ticks; 2^32 saturates to all ones
    function automatic bit [31:0] step_for(input bit [63:0] beat_ticks);
        bit [63:0] q;
        q = 64'h1_0000_0000 / beat_ticks;
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    // Phase reset, held off near the wrap in external sync mode
    function automatic void sync_phase();
        if (ext_sync && acc > sync_guard)
            return;
        acc = '0;
        beat_q = 1'b1;
        resync = 1'b0;
    endfunction

    // Advances the clock state by one request and returns its result
    function automatic clock_result_t next_clock_state(input bit [2:0] op,
                                                       input bit [31:0] val);
        clock_result_t r;
        bit [31:0]     prev;
        bit [31:0]     pp;
        bit [31:0]     cp;
        bit [31:0]     ival;
        bit [63:0]     beat_ticks;
        bit [63:0]     t;
        bit [63:0]     rd;
        bit            took;
        took = 1'b0;
        case (op)
            ttpc_pkg::OP_TICK:
            begin
                prev = acc;
                acc = acc + step;
                beat_q = prev > acc;
                pp = prev << sub_shift;
                cp = acc << sub_shift;
                if (pp > cp)
                    sub_cnt = sub_cnt + 16'd1;
                tick_total = tick_total + 32'd1;
                if (sub_cnt >= sub_div)
                begin
                    sub_q = 1'b1;
                    sub_cnt = '0;
                    resync = 1'b1;
                end
                else
                    sub_q = 1'b0;
                // subclock count realigns on the next main beat
                if (resync && beat_q)
                begin
                    sub_cnt = '0;
                    resync = 1'b0;
                end
            end
            ttpc_pkg::OP_TAP:
            begin
                if (!tap_held)
                begin
                    tap_prev = val;
                    tap_held = 1'b1;
                end
                else
                begin
                    ival = val - tap_prev;
                    if (ival < tap_min || ival > tap_max)
                        tap_held = 1'b0;
                    else
                    begin
                        tap_prev = val;
                        if (ival != 0)
                            step = step_for({32'd0, ival});
                        sync_phase();
                        took = (ival != 0);
                    end
                end
            end
            ttpc_pkg::OP_SYNC:
                sync_phase();
            ttpc_pkg::OP_SET_BPM:
            begin
                if (val != 0)
                begin
                    beat_ticks = ({40'd0, speed_hz} * ttpc_pkg::TEMPO_SCALE)
                                 / {32'd0, val};
                    if (beat_ticks != 0)
                        step = step_for(beat_ticks);
                end
            end
            ttpc_pkg::OP_SET_DIV:
            begin
                sub_div = (val > 32'hFFFF) ? 16'hFFFF : val[15:0];
                resync = 1'b1;
                if (ext_sync)
                    sync_phase();
            end
            default: ;
        endcase
        // tempo readout, split to keep the product inside 64 bits
        rd = '0;
        if (step != 0)
        begin
            t = {32'd0, step} * {40'd0, speed_hz};
            rd = (t >> 32) * ttpc_pkg::TEMPO_SCALE
                 + (((t & 64'hFFFF_FFFF) * ttpc_pkg::TEMPO_SCALE) >> 32);
        end
        r.ph = acc;
        r.beat = beat_q;
        r.sub = sub_q;
        r.ticks = tick_total;
        r.tempo = (rd > 64'hFFFF) ? 16'hFFFF : rd[15:0];
        r.tap_ok = took;
        return r;
    endfunction

    // Request and register monitor, result checker, result stall
    always @(posedge clk)
    begin : monitor
        script_expect_t note;
        clock_result_t  want;
        clock_result_t  predicted;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ttpc_pkg::CFG_CLOCK_SPEED: speed_hz = cfg_data[23:0];
                    ttpc_pkg::CFG_SUB_SHIFT:   sub_shift = cfg_data[4:0];
                    ttpc_pkg::CFG_MIN_INTV:    tap_min = cfg_data;
                    ttpc_pkg::CFG_MAX_INTV:    tap_max = cfg_data;
                    ttpc_pkg::CFG_WRAP_THR:    sync_guard = cfg_data;
                    ttpc_pkg::CFG_EXT_SYNC:    ext_sync = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                note = '0;
                if (script_expects.size() != 0)
                    note = script_expects.pop_front();
                predicted = next_clock_state(opcode, value);
                pending_results.push_back(note.known ? note.want : predicted);
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                    report_error("result with no request pending");
                else
                begin
                    want = pending_results.pop_front();
                    if (phase !== want.ph)
                        report_error($sformatf("phase %h, want %h", phase, want.ph));
                    if (beat_pulse !== want.beat)
                        report_error($sformatf("beat_pulse %b, want %b", beat_pulse, want.beat));
                    if (subclock_pulse !== want.sub)
                        report_error($sformatf("subclock_pulse %b, want %b",
                                               subclock_pulse, want.sub));
                    if (tick_count !== want.ticks)
                        report_error($sformatf("tick_count %h, want %h",
                                               tick_count, want.ticks));
                    if (tempo_bpm10 !== want.tempo)
                        report_error($sformatf("tempo_bpm10 %0d, want %0d",
                                               tempo_bpm10, want.tempo));
                    if (tap_accepted !== want.tap_ok)
                        report_error($sformatf("tap_accepted %b, want %b",
                                               tap_accepted, want.tap_ok));
                end
                result_index++;
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic void add_step(input bit is_reg, input bit [2:0] code,
                                     input bit [31:0] data, input bit known,
                                     input clock_result_t want);
        script_row_t row;
        row.is_reg = is_reg;
        row.code = code;
        row.data = data;
        row.known = known;
        row.want = want;
        script.push_back(row);
    endfunction

    // Presents one request after random idle cycles, returns once taken
    task automatic send_request(input bit [2:0] op, input bit [31:0] val,
                                input bit known, input clock_result_t want);
        script_expect_t note;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        note.known = known;
        note.want = want;
        script_expects.push_back(note);
        in_valid <= 1'b1;
        opcode <= op;
        value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stops sending and waits for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic write_reg(input bit [2:0] idx, input bit [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : main
        clock_result_t none;
        bit [2:0]      op;
        bit [31:0]     val;
        bit [31:0]     lo;
        bit [31:0]     hi;
        bit [31:0]     gap;
        bit [63:0]     bpm;
        int            roll;

        none = '0;
        // reset values of the registers and the clock state
        speed_hz = ttpc_pkg::RST_CLOCK_SPEED;
        sub_shift = ttpc_pkg::RST_SUB_SHIFT;
        tap_min = ttpc_pkg::RST_MIN_INTV;
        tap_max = ttpc_pkg::RST_MAX_INTV;
        sync_guard = ttpc_pkg::RST_WRAP_THR;
        ext_sync = 1'b0;
        acc = '0;
        step = '0;
        beat_q = 1'b0;
        sub_q = 1'b0;
        sub_cnt = '0;
        sub_div = 16'd1;
        resync = 1'b0;
        tick_total = '0;
        tap_prev = '0;
        tap_held = 1'b0;

        // stopped clock after reset: nothing moves, first tap only arms
        add_step(1'b0, ttpc_pkg::OP_TICK, 32'd0, 1'b1,
                 '{32'd0, 1'b0, 1'b0, 32'd1, 16'd0, 1'b0});
        add_step(1'b0, ttpc_pkg::OP_TAP, 32'd0, 1'b1,
                 '{32'd0, 1'b0, 1'b0, 32'd1, 16'd0, 1'b0});
        add_step(1'b0, ttpc_pkg::OP_SYNC, 32'd0, 1'b1,
                 '{32'd0, 1'b1, 1'b0, 32'd1, 16'd0, 1'b0});
        // divisor zero pulses the subclock on every tick
        add_step(1'b0, ttpc_pkg::OP_SET_DIV, 32'd0, 1'b1,
                 '{32'd0, 1'b1, 1'b0, 32'd1, 16'd0, 1'b0});
        add_step(1'b0, ttpc_pkg::OP_TICK, 32'd0, 1'b1,
                 '{32'd0, 1'b0, 1'b1, 32'd2, 16'd0, 1'b0});
        add_step(1'b0, OP_SPARE_C, 32'hFFFF_FFFF, 1'b1,
                 '{32'd0, 1'b0, 1'b1, 32'd2, 16'd0, 1'b0});
        // zero tempo and zero ticks per beat are ignored
        add_step(1'b0, ttpc_pkg::OP_SET_BPM, 32'd0, 1'b1,
                 '{32'd0, 1'b0, 1'b1, 32'd2, 16'd0, 1'b0});
        add_step(1'b0, ttpc_pkg::OP_SET_BPM, 32'hFFFF_FFFF, 1'b1,
                 '{32'd0, 1'b0, 1'b1, 32'd2, 16'd0, 1'b0});
        // tap intervals at and just past the accepted range
        add_step(1'b0, ttpc_pkg::OP_TAP, 32'd4800, 1'b0, none);
        add_step(1'b0, ttpc_pkg::OP_TICK, 32'd0, 1'b0, none);
        add_step(1'b0, ttpc_pkg::OP_TAP, 32'd9599, 1'b0, none);
        add_step(1'b0, ttpc_pkg::OP_TAP, 32'hFFFF_FFFF, 1'b0, none);
        add_step(1'b0, ttpc_pkg::OP_TAP, 32'd479999, 1'b0, none);
        add_step(1'b0, ttpc_pkg::OP_TAP, 32'd960000, 1'b0, none);
        // one tick per beat: step saturates, readout saturates
        add_step(1'b0, ttpc_pkg::OP_SET_BPM, 32'd28800000, 1'b0, none);
        add_step(1'b0, ttpc_pkg::OP_TICK, 32'd0, 1'b0, none);
        add_step(1'b0, ttpc_pkg::OP_TICK, 32'd0, 1'b0, none);
        add_step(1'b0, ttpc_pkg::OP_SET_DIV, 32'hFFFF_FFFF, 1'b0, none);
        add_step(1'b0, OP_SPARE_A, 32'h5A5A_A5A5, 1'b0, none);
        // external sync with the reset suppressed above phase zero
        add_step(1'b1, ttpc_pkg::CFG_EXT_SYNC, 32'd1, 1'b0, none);
        add_step(1'b1, ttpc_pkg::CFG_WRAP_THR, 32'd0, 1'b0, none);
        add_step(1'b1, ttpc_pkg::CFG_MIN_INTV, 32'd0, 1'b0, none);
        add_step(1'b1, CFG_UNUSED, 32'hFFFF_FFFF, 1'b0, none);
        add_step(1'b0, ttpc_pkg::OP_TICK, 32'd0, 1'b0, none);
        add_step(1'b0, ttpc_pkg::OP_SYNC, 32'd0, 1'b0, none);
        add_step(1'b0, ttpc_pkg::OP_SET_DIV, 32'd2, 1'b0, none);
        add_step(1'b0, ttpc_pkg::OP_TAP, 32'd77, 1'b0, none);
        add_step(1'b0, ttpc_pkg::OP_TAP, 32'd77, 1'b0, none);
        // zero tap interval with the reset allowed
        add_step(1'b1, ttpc_pkg::CFG_WRAP_THR, 32'hFFFF_FFFF, 1'b0, none);
        add_step(1'b0, ttpc_pkg::OP_TAP, 32'd77, 1'b0, none);
        add_step(1'b0, OP_SPARE_B, 32'd0, 1'b0, none);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // scripted part
        foreach (script[i])
        begin
            if (script[i].is_reg)
            begin
                drain_results();
                write_reg(script[i].code, script[i].data);
            end
            else
                send_request(script[i].code, script[i].data, script[i].known, script[i].want);
        end
        drain_results();

        // random part, one register setting per phase
        for (int p = 0; p < PHASES; p++)
        begin
            send_idle_pct = (p % 4 == 1) ? 71 : (p % 4 == 3) ? 30 : 0;
            stall_pct = (p % 4 == 2) ? 71 : (p % 4 == 3) ? 30 : 0;

            write_reg(ttpc_pkg::CFG_CLOCK_SPEED, (p == 1) ? 32'd1 :
                      (p == 2) ? 32'hFF_FFFF :
                      (p == 5) ? 32'd48000 : $urandom_range(20, 5000));
            write_reg(ttpc_pkg::CFG_SUB_SHIFT, (p == 1) ? 32'd0 : (p == 2) ? 32'd31 :
                      $urandom_range(0, 31));
            if (p == 3)
            begin
                write_reg(ttpc_pkg::CFG_MIN_INTV, 32'd0);
                write_reg(ttpc_pkg::CFG_MAX_INTV, 32'hFFFF_FFFF);
            end
            else if (p == 4)
            begin
                write_reg(ttpc_pkg::CFG_MIN_INTV, 32'hFFFF_FFFF);
                write_reg(ttpc_pkg::CFG_MAX_INTV, 32'd0);
            end
            else
            begin
                lo = $urandom_range(0, 8);
                write_reg(ttpc_pkg::CFG_MIN_INTV, lo);
                write_reg(ttpc_pkg::CFG_MAX_INTV, lo + $urandom_range(20, 400));
            end
            write_reg(ttpc_pkg::CFG_WRAP_THR, (p == 3) ? 32'd0 :
                      (p == 6) ? 32'hFFFF_FFFF : $urandom);
            write_reg(ttpc_pkg::CFG_EXT_SYNC, p % 2);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                val = $urandom;
                if (roll < 62)
                    op = ttpc_pkg::OP_TICK;
                else if (roll < 74)
                begin
                    // taps mostly land inside the accepted range
                    op = ttpc_pkg::OP_TAP;
                    lo = tap_min;
                    hi = tap_max;
                    if ($urandom_range(0, 9) == 0 || lo > hi)
                        gap = $urandom;
                    else if (lo == 0 && $urandom_range(0, 7) == 0)
                        gap = 0;
                    else
                        gap = lo + $urandom_range(0, (hi - lo > 300) ? 300 : hi - lo);
                    val = last_tap_sent + gap;
                    last_tap_sent = val;
                end
                else if (roll < 80)
                begin
                    // tempo giving a short beat, in ticks
                    op = ttpc_pkg::OP_SET_BPM;
                    bpm = ({40'd0, speed_hz} * ttpc_pkg::TEMPO_SCALE)
                          / $urandom_range(1, 64) + $urandom_range(0, 2);
                    if ($urandom_range(0, 7) != 0)
                        val = (bpm > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : bpm[31:0];
                end
                else if (roll < 85)
                    op = ttpc_pkg::OP_SYNC;
                else if (roll < 91)
                begin
                    op = ttpc_pkg::OP_SET_DIV;
                    if ($urandom_range(0, 7) != 0)
                        val = $urandom_range(0, 6);
                end
                else
                    op = 3'($urandom_range(0, 7));
                send_request(op, val, 1'b0, none);
                // hold the sender once until everything has come back
                if (n == PHASE_ITEMS / 2)
                    drain_results();
            end
            drain_results();
        end

        repeat (8) @(posedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
